>>> design/oli_pkg.sv
package oli_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_ERASE      = 3'd5,
        REQ_DUMP       = 3'd6
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    localparam int REQ_TYPE_W = 3;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ELEMENT_W  = 32;
    localparam int COUNT_W    = 7;

endpackage

>>> design/oli_if.sv
interface oli_req_if
    import oli_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POSITION_W-1:0] position;
    logic [VALUE_W-1:0]    value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface oli_rsp_if
    import oli_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ELEMENT_W-1:0] element;
    logic [COUNT_W-1:0]   count;
    logic                 last;

    modport source (output valid, output status, output element, output count,
                    output last, input ready);
    modport sink   (input valid, input status, input element, input count,
                    input last, output ready);
endinterface

>>> design/oli_ram.sv
module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ordered_list_insert_delete.sv
// ordered list held in a small ram, one request at a time
//
// channels: req carries req_type, position and value; rsp carries status,
// element, count and last. both are valid/ready, an item moves when both
// are high at a rising edge of clk.
//
// push, pop, insert and erase each give one result with the new count.
// dump gives one result per element front to back, last set on the final
// one, or a single result with count zero on an empty list.
//
// moving an element takes a ram read (S_RD) then a write one place over
// (S_WR). push back, push front and insert write the new value in S_PLACE.
// dump reads each element (S_DRD) then hands it over (S_DOUT).
// req.ready is high only in idle and rises together with the result,
// so a new item can be taken while that result is still shown.
//
// reset (rst_n low, asynchronous) empties the list and drops any pending
// result, ram contents stay. when rsp stalls the result holds in the output
// register and the block waits before loading the next one into it.
module ordered_list_insert_delete
    import oli_pkg::*;
#(
    parameter int LIST_CAPACITY = 16,
    parameter int DATA_WIDTH    = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    oli_req_if.sink   req,
    oli_rsp_if.source rsp
);

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_C = CW'(LIST_CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,  // read the neighbor of idx
        S_WR    = 7'b0000100,  // write it back at idx
        S_PLACE = 7'b0001000,  // drop the new value into its slot
        S_RESP  = 7'b0010000,  // hand over the single result
        S_DRD   = 7'b0100000,  // dump: read element idx
        S_DOUT  = 7'b1000000   // dump: hand it over
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            dir_up_reg, dir_up_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    status_t         status_reg, status_next;

    // output register
    logic                 rsp_valid_reg;
    logic [STATUS_W-1:0]  rsp_status_reg;
    logic [ELEMENT_W-1:0] rsp_element_reg;
    logic [COUNT_W-1:0]   rsp_count_reg;
    logic                 rsp_last_reg;
    logic                 rsp_load;
    logic [STATUS_W-1:0]  rsp_status_next;
    logic [ELEMENT_W-1:0] rsp_element_next;
    logic                 rsp_last_next;
    logic                 out_free;

    // ram ports
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // shared index unit: one step toward the element to move
    logic [CW-1:0] step;
    logic          step_more_up;
    logic          step_more_down;

    logic [CW-1:0] req_pos;
    logic          pos_in_range;
    logic          list_full;
    logic          list_empty;
    logic          erase_moves;

    assign step           = dir_up_reg ? (idx_reg + CW'(1)) : (idx_reg - CW'(1));
    assign step_more_up   = ({1'b0, step} + (CW + 1)'(1)) < {1'b0, count_reg};
    assign step_more_down = step > pos_reg;

    assign req_pos      = CW'(req.position);
    assign pos_in_range = COUNT_W'(req.position) < COUNT_W'(count_reg);
    assign list_full    = count_reg == CAP_C;
    assign list_empty   = count_reg == '0;
    // erase shifts only when something sits above the position
    assign erase_moves  = ({1'b0, req_pos} + (CW + 1)'(1)) < {1'b0, count_reg};

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        dir_up_next      = dir_up_reg;
        val_next         = val_reg;
        status_next      = status_reg;
        rsp_load         = 1'b0;
        rsp_status_next  = status_reg;
        rsp_element_next = '0;
        rsp_last_next    = 1'b1;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[AW-1:0];
        ram_wdata        = ram_rdata;
        ram_re           = 1'b0;
        ram_raddr        = step[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = ST_OK;
                    val_next    = DATA_WIDTH'($signed(req.value));
                    unique case (req_t'(req.req_type))
                        REQ_PUSH_BACK:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = S_PLACE;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            state_next = S_RESP;
                        end
                        REQ_PUSH_FRONT:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                pos_next    = '0;
                                idx_next    = count_reg;
                                dir_up_next = 1'b0;
                                state_next  = list_empty ? S_PLACE : S_RD;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (list_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else if (count_reg > CW'(1))
                            begin
                                idx_next    = '0;
                                dir_up_next = 1'b1;
                                state_next  = S_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_RESP;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (!pos_in_range)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_RESP;
                            end
                            else if (list_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                // position below count, so one move at least
                                pos_next    = req_pos;
                                idx_next    = count_reg;
                                dir_up_next = 1'b0;
                                state_next  = S_RD;
                            end
                        end
                        REQ_ERASE:
                        begin
                            if (!pos_in_range)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_RESP;
                            end
                            else if (erase_moves)
                            begin
                                idx_next    = req_pos;
                                dir_up_next = 1'b1;
                                state_next  = S_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_RESP;
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (list_empty)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DRD;
                            end
                        end
                        default:
                        begin
                            // unused code: taken and dropped
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = step[AW-1:0];
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = step;
                if (dir_up_reg)
                begin
                    if (step_more_up)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    state_next = step_more_down ? S_RD : S_PLACE;
                end
            end
            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_load        = 1'b1;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            S_DRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (out_free)
                begin
                    rsp_load         = 1'b1;
                    rsp_status_next  = ST_OK;
                    rsp_element_next = ELEMENT_W'($signed(ram_rdata));
                    rsp_last_next    = (idx_reg + CW'(1)) == count_reg;
                    idx_next         = idx_reg + CW'(1);
                    state_next       = rsp_last_next ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        dir_up_reg <= dir_up_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        if (rsp_load)
        begin
            rsp_status_reg  <= rsp_status_next;
            rsp_element_reg <= rsp_element_next;
            rsp_count_reg   <= COUNT_W'(count_reg);
            rsp_last_reg    <= rsp_last_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.element = rsp_element_reg;
    assign rsp.count   = rsp_count_reg;
    assign rsp.last    = rsp_last_reg;

    oli_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (LIST_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> design/oli_checker.sv
module oli_checker
    import oli_pkg::*;
#(
    parameter int LIST_CAPACITY = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic [REQ_TYPE_W-1:0] req_type,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [STATUS_W-1:0]   rsp_status,
    input logic [ELEMENT_W-1:0]  rsp_element,
    input logic [COUNT_W-1:0]    rsp_count,
    input logic                  rsp_last
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_element) && $stable(rsp_count) && $stable(rsp_last))
        else $error("stalled result changed");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_count <= COUNT_W'(LIST_CAPACITY))
        else $error("count above capacity");

    // an error result is always a single result with no element
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_element == '0)
        else $error("error result not single");

    // a real request (any code up to dump) takes the block out of idle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type <= REQ_DUMP |=> !req_ready)
        else $error("ready right after a request");

endmodule

bind ordered_list_insert_delete oli_checker #(
    .LIST_CAPACITY (LIST_CAPACITY)
) u_oli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_element (rsp.element),
    .rsp_count   (rsp.count),
    .rsp_last    (rsp.last)
);
